@@ design/sbst_pkg.sv @@
// shared types and constants for the segment versus padded box slab test
// no dependencies; imported by every module of the block
package sbst_pkg;

	// padding register
	localparam int unsigned PAD_W = 20;
	localparam logic [PAD_W-1:0] PAD_RESET = 20'd1311;

	// configuration port
	localparam int unsigned APB_AW = 3;
	localparam int unsigned APB_DW = 32;
	localparam logic [0:0] REG_BOX_PADDING = 1'b0;

	// per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} sbst_en_t;

	// per-axis status leaving the front end
	typedef struct packed {
		logic moving;
		logic in_slab;
	} sbst_flags_t;

endpackage

@@ design/sbst_axis.sv @@
// one axis of the slab test: padded bounds, delta, entry and exit numerators
// stages s1 to s3; depends on sbst_pkg
module sbst_axis import sbst_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  sbst_en_t                      en,
	input  logic [PAD_W-1:0]              pad,
	input  logic signed [COORD_WIDTH-1:0] s,
	input  logic signed [COORD_WIDTH-1:0] e,
	input  logic signed [COORD_WIDTH-1:0] bmin,
	input  logic signed [COORD_WIDTH-1:0] bmax,
	output sbst_flags_t                   flags_s3,
	output logic signed [COORD_WIDTH:0]   n1_s3,
	output logic signed [COORD_WIDTH:0]   n2_s3,
	output logic [COORD_WIDTH-1:0]        den_s3
);

	localparam int CW = COORD_WIDTH;
	localparam int EW = ((CW > PAD_W) ? CW : PAD_W) + 2;
	localparam logic signed [EW-1:0] PMAX_E = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [EW-1:0] PMIN_E = {{(EW-CW+1){1'b1}}, {(CW-1){1'b0}}};

	logic signed [EW-1:0] pad_e, lo_e, hi_e;
	logic signed [CW-1:0] lo_c, hi_c;
	logic signed [CW:0]   d_c;

	logic signed [CW-1:0] lo_s1, hi_s1, s_s1;
	logic signed [CW:0]   d_s1;

	logic signed [CW-1:0] lo_s2, hi_s2, s_s2;
	logic [CW-1:0]        den_s2;
	logic                 neg_s2, swp_s2;
	sbst_flags_t          flags_s2;

	logic signed [CW-1:0] min_b, max_b, ea, eb, xa, xb;

	// stage 1: widen and saturate the bounds, take the delta
	always_comb begin
		pad_e = $signed({{(EW-PAD_W){1'b0}}, pad});
		lo_e = EW'(bmin) - pad_e;
		hi_e = EW'(bmax) + pad_e;
		lo_c = (lo_e < PMIN_E) ? PMIN_E[CW-1:0] : lo_e[CW-1:0];
		hi_c = (hi_e > PMAX_E) ? PMAX_E[CW-1:0] : hi_e[CW-1:0];
		d_c = (CW+1)'(e) - (CW+1)'(s);
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			lo_s1 <= lo_c;
			hi_s1 <= hi_c;
			s_s1 <= s;
			d_s1 <= d_c;
		end
	end

	// stage 2: direction, magnitude, bound order, containment
	always_ff @(posedge clk) begin
		if (en.s2) begin
			lo_s2 <= lo_s1;
			hi_s2 <= hi_s1;
			s_s2 <= s_s1;
			neg_s2 <= d_s1[CW];
			den_s2 <= d_s1[CW] ? CW'(-d_s1) : CW'(d_s1);
			swp_s2 <= lo_s1 > hi_s1;
			flags_s2.moving <= |d_s1;
			flags_s2.in_slab <= !(s_s1 < lo_s1) && !(s_s1 > hi_s1);
		end
	end

	// stage 3: ordered entry and exit numerators over a positive denominator
	always_comb begin
		min_b = swp_s2 ? hi_s2 : lo_s2;
		max_b = swp_s2 ? lo_s2 : hi_s2;
		ea = neg_s2 ? s_s2 : min_b;
		eb = neg_s2 ? max_b : s_s2;
		xa = neg_s2 ? s_s2 : max_b;
		xb = neg_s2 ? min_b : s_s2;
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			n1_s3 <= (CW+1)'(ea) - (CW+1)'(eb);
			n2_s3 <= (CW+1)'(xa) - (CW+1)'(xb);
			den_s3 <= den_s2;
			flags_s3 <= flags_s2;
		end
	end

endmodule

@@ design/sbst_mul.sv @@
// signed numerator times unsigned denominator, split into four partial products
// stages s4 to s6; depends on sbst_pkg
module sbst_mul import sbst_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                            clk,
	input  sbst_en_t                        en,
	input  logic signed [COORD_WIDTH:0]     n,
	input  logic [COORD_WIDTH-1:0]          den,
	output logic signed [2*COORD_WIDTH+1:0] prod_s6
);

	localparam int CW  = COORD_WIDTH;
	localparam int NW  = CW + 1;
	localparam int H   = (CW + 2) / 2;
	localparam int PW  = 2 * CW + 2;
	localparam int P3W = NW + CW - 2 * H + 1;

	logic [H-1:0]             n_lo, d_lo;
	logic signed [NW-H-1:0]   n_hi;
	logic [CW-H-1:0]          d_hi;
	logic signed [H:0]        d_lo_s;
	logic signed [CW-H:0]     d_hi_s;

	logic [2*H-1:0]           pp0_s4;
	logic signed [NW:0]       pp1_s4;
	logic [CW-1:0]            pp2_s4;
	logic signed [P3W-1:0]    pp3_s4;

	logic signed [PW-1:0]     base_s5;
	logic signed [NW+1:0]     mid_s5;

	always_comb begin
		n_lo = n[H-1:0];
		n_hi = n[NW-1:H];
		d_lo = den[H-1:0];
		d_hi = den[CW-1:H];
		d_lo_s = $signed({1'b0, d_lo});
		d_hi_s = $signed({1'b0, d_hi});
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			pp0_s4 <= (2*H)'(n_lo) * (2*H)'(d_lo);
			pp1_s4 <= (NW+1)'(n_hi) * (NW+1)'(d_lo_s);
			pp2_s4 <= CW'(n_lo) * CW'(d_hi);
			pp3_s4 <= P3W'(n_hi) * P3W'(d_hi_s);
		end
	end

	// outer products sit side by side, cross terms are summed
	always_ff @(posedge clk) begin
		if (en.s5) begin
			base_s5 <= {pp3_s4, pp0_s4};
			mid_s5 <= (NW+2)'(pp1_s4) + (NW+2)'($signed({1'b0, pp2_s4}));
		end
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			prod_s6 <= base_s5 + (PW'(mid_s5) <<< H);
		end
	end

endmodule

@@ design/segment_box_slab_test.sv @@
// top level of the segment versus padded box slab test
// depends on sbst_pkg, sbst_axis and sbst_mul
//
// usage
//  - input channel (in_valid / in_stall) carries one word per test: segment
//    start and end, box bounds, all signed Q16.16 of COORD_WIDTH bits
//  - output channel (out_valid / out_stall) returns one word per test: hit
//  - box_padding is written over the apb-style port at byte address 0 and
//    reads back on prdata; the user must write it only while no word is in
//    flight, and the block itself does not enforce this
//  - a word accepted at a rising edge passes the seven register stages to
//    out_valid; a new word can be taken every cycle while in_stall is low
//  - the stages are: bounds and delta, order and containment, numerators,
//    partial products, cross-term sum, products, final compare
//  - each stage moves when the stage after it is empty or moving, so bubbles
//    close up and in_stall only rises with all seven stages full and the
//    receiver stalling; a stalled hit word holds
//  - reset clears all valid bits and sets box_padding to 1311 (about 0.02)
module segment_box_slab_test import sbst_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input word
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	input  logic signed [COORD_WIDTH-1:0] box_min_x,
	input  logic signed [COORD_WIDTH-1:0] box_max_x,
	input  logic signed [COORD_WIDTH-1:0] box_min_y,
	input  logic signed [COORD_WIDTH-1:0] box_max_y,
	// output word
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [APB_AW-1:0]             paddr,
	input  logic [APB_DW-1:0]             pwdata,
	output logic [APB_DW-1:0]             prdata,
	output logic                          pready
);

	localparam int CW = COORD_WIDTH;

	// padding register
	logic [PAD_W-1:0] pad_q;
	logic             cfg_wr;

	// stage handshake
	logic     v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic     rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;
	sbst_en_t en;

	// axis front-end results
	sbst_flags_t          fx_s3, fy_s3;
	logic signed [CW:0]   n1x_s3, n2x_s3, n1y_s3, n2y_s3;
	logic [CW-1:0]        denx_s3, deny_s3;

	// per-axis simple checks
	logic okx_c, oky_c;
	logic okx_s4, oky_s4, both_s4;
	logic okx_s5, oky_s5, both_s5;
	logic okx_s6, oky_s6, both_s6;

	// cross products
	logic signed [2*CW+1:0] pa_s6, pb_s6, pc_s6, pd_s6;
	logic                   hit_s7;

	// configuration port: writes take effect on the access cycle
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[APB_AW-1] == REG_BOX_PADDING);
	assign prdata = (paddr[APB_AW-1] == REG_BOX_PADDING) ? APB_DW'(pad_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q <= PAD_RESET;
		end else if (cfg_wr) begin
			pad_q <= pwdata[PAD_W-1:0];
		end
	end

	// a stage loads when it is empty or its word moves on
	assign rdy7 = !v_s7 || !out_stall;
	assign rdy6 = !v_s6 || rdy7;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign en.s1 = rdy1;
	assign en.s2 = rdy2;
	assign en.s3 = rdy3;
	assign en.s4 = rdy4;
	assign en.s5 = rdy5;
	assign en.s6 = rdy6;
	assign en.s7 = rdy7;

	assign in_stall = !rdy1;
	assign out_valid = v_s7;
	assign hit = hit_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
			if (rdy7) v_s7 <= v_s6;
		end
	end

	// stages s1 to s3, one slab each
	sbst_axis #(.COORD_WIDTH(CW)) u_axis_x (
		.clk      (clk),
		.en       (en),
		.pad      (pad_q),
		.s        (start_x),
		.e        (end_x),
		.bmin     (box_min_x),
		.bmax     (box_max_x),
		.flags_s3 (fx_s3),
		.n1_s3    (n1x_s3),
		.n2_s3    (n2x_s3),
		.den_s3   (denx_s3)
	);

	sbst_axis #(.COORD_WIDTH(CW)) u_axis_y (
		.clk      (clk),
		.en       (en),
		.pad      (pad_q),
		.s        (start_y),
		.e        (end_y),
		.bmin     (box_min_y),
		.bmax     (box_max_y),
		.flags_s3 (fy_s3),
		.n1_s3    (n1y_s3),
		.n2_s3    (n2y_s3),
		.den_s3   (deny_s3)
	);

	// a moving axis needs exit at or after 0 and entry at or before 1;
	// a still axis needs the start inside its padded slab
	always_comb begin
		okx_c = fx_s3.moving
			? (!n2x_s3[CW] && (n1x_s3 <= $signed({1'b0, denx_s3})))
			: fx_s3.in_slab;
		oky_c = fy_s3.moving
			? (!n2y_s3[CW] && (n1y_s3 <= $signed({1'b0, deny_s3})))
			: fy_s3.in_slab;
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			okx_s4 <= okx_c;
			oky_s4 <= oky_c;
			both_s4 <= fx_s3.moving && fy_s3.moving;
		end
		if (en.s5) begin
			okx_s5 <= okx_s4;
			oky_s5 <= oky_s4;
			both_s5 <= both_s4;
		end
		if (en.s6) begin
			okx_s6 <= okx_s5;
			oky_s6 <= oky_s5;
			both_s6 <= both_s5;
		end
	end

	// cross terms: entry of one axis against exit of the other,
	// compared as n1x/dx <= n2y/dy and n1y/dy <= n2x/dx
	sbst_mul #(.COORD_WIDTH(CW)) u_mul_a (
		.clk     (clk),
		.en      (en),
		.n       (n1x_s3),
		.den     (deny_s3),
		.prod_s6 (pa_s6)
	);

	sbst_mul #(.COORD_WIDTH(CW)) u_mul_b (
		.clk     (clk),
		.en      (en),
		.n       (n2y_s3),
		.den     (denx_s3),
		.prod_s6 (pb_s6)
	);

	sbst_mul #(.COORD_WIDTH(CW)) u_mul_c (
		.clk     (clk),
		.en      (en),
		.n       (n1y_s3),
		.den     (denx_s3),
		.prod_s6 (pc_s6)
	);

	sbst_mul #(.COORD_WIDTH(CW)) u_mul_d (
		.clk     (clk),
		.en      (en),
		.n       (n2x_s3),
		.den     (deny_s3),
		.prod_s6 (pd_s6)
	);

	// stage 7: a touch on a boundary counts, hence the non-strict compares
	always_ff @(posedge clk) begin
		if (en.s7) begin
			hit_s7 <= okx_s6 && oky_s6
				&& (!both_s6 || ((pa_s6 <= pb_s6) && (pc_s6 <= pd_s6)));
		end
	end

endmodule

@@ design/sbst_check.sv @@
// port-level checks for the slab test block, bound to the top level
// depends on sbst_pkg and segment_box_slab_test
module sbst_check import sbst_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic              hit,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [APB_AW-1:0] paddr,
	input logic [APB_DW-1:0] pwdata,
	input logic [APB_DW-1:0] prdata
);

	logic in_acc;
	logic pad_wr;

	assign in_acc = in_valid && !in_stall;
	assign pad_wr = psel && penable && pwrite && (paddr[APB_AW-1] == REG_BOX_PADDING);

	// a stalled hit word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit))
		else $error("hit word changed while stalled");

	// input only backs up when the output word is valid and the receiver stalls
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// with no back-pressure an accepted word is not held back on its way to out_valid
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
		##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("word did not reach the output in time");

	// padding reads back what was last written
	a_pad_readback: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $past(pad_wr) && (paddr[APB_AW-1] == REG_BOX_PADDING)
		|-> prdata == APB_DW'($past(pwdata[PAD_W-1:0])))
		else $error("padding read-back mismatch");

endmodule

bind segment_box_slab_test sbst_check u_sbst_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.hit       (hit),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);
